// ===== rtl/clxm_pkg.sv =====
// Shared types and constants for the combined LCG / xorshift / MWC generator.
// No dependencies; used by the core and the testbench.
package clxm_pkg;

  localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD = 64'd7046029254386353087;
  localparam logic [63:0] XS_SEED = 64'd4101842887655102017;
  localparam logic [31:0] MWC_MUL = 32'd4294957665;

  // Sequencer states: idle, restart load, four multiplier passes, restart fixup, output.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_FIX,
    ST_OUT
  } seq_state_t;

  // 17/31/8 xorshift step
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> 17);
    v = v ^ (v << 31);
    v = v ^ (v >> 8);
    return v;
  endfunction

  // 21/35/4 tempering of the LCG word
  function automatic logic [63:0] lcg_temper(input logic [63:0] l);
    logic [63:0] t;
    t = l ^ (l << 21);
    t = t ^ (t >> 35);
    t = t ^ (t << 4);
    return t;
  endfunction

endpackage

// ===== rtl/combined_lcg_xorshift_mwc_rng_core.sv =====
// Combined 64-bit random word generator core (LCG + xorshift + MWC).
// Depends on clxm_pkg for constants, the sequencer state type and step functions.

// One item in, one 64-bit deviate out. Between acceptance and the result on
// m_tvalid, a plain item makes four passes through a single shared 32x32
// multiplier (three partial products for the 64-bit LCG multiply, one for the
// MWC step) and then the output state forms the tempered output. An item with
// restart set first loads the state from the seed register and runs three
// extra discarded steps, each ending in a fixup state. s_tready is high
// only while the sequencer is idle, so the block holds one item at a time; a
// finished result waits in the output register while the next item is taken.
// The seed register may be written only while the block is idle.
module combined_lcg_xorshift_mwc_rng_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_value_we,
  input  logic [63:0] seed_value,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [63:0] deviate
);

  clxm_pkg::seq_state_t state, state_next;

  logic [63:0] seed_reg;
  logic [63:0] lcg_word;
  logic [63:0] xorshift_word;
  logic [63:0] mwc_word;
  logic [63:0] acc;
  logic [1:0]  fix_cnt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic        in_fire;
  logic        out_free;

  assign s_tready = (state == clxm_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Shared multiplier operand select
  always_comb begin
    mul_a = lcg_word[31:0];
    mul_b = clxm_pkg::LCG_MUL[31:0];
    case (state)
      clxm_pkg::ST_P1: begin
        mul_a = lcg_word[63:32];
        mul_b = clxm_pkg::LCG_MUL[31:0];
      end
      clxm_pkg::ST_P2: begin
        mul_a = lcg_word[31:0];
        mul_b = clxm_pkg::LCG_MUL[63:32];
      end
      clxm_pkg::ST_P3: begin
        mul_a = mwc_word[31:0];
        mul_b = clxm_pkg::MWC_MUL;
      end
      default: begin
        mul_a = lcg_word[31:0];
        mul_b = clxm_pkg::LCG_MUL[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clxm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      clxm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = s_tdata[0] ? clxm_pkg::ST_SEED : clxm_pkg::ST_P0;
        end
      end
      clxm_pkg::ST_SEED: state_next = clxm_pkg::ST_P0;
      clxm_pkg::ST_P0:   state_next = clxm_pkg::ST_P1;
      clxm_pkg::ST_P1:   state_next = clxm_pkg::ST_P2;
      clxm_pkg::ST_P2:   state_next = clxm_pkg::ST_P3;
      clxm_pkg::ST_P3: begin
        state_next = (fix_cnt != 2'd0) ? clxm_pkg::ST_FIX : clxm_pkg::ST_OUT;
      end
      clxm_pkg::ST_FIX:  state_next = clxm_pkg::ST_P0;
      clxm_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = clxm_pkg::ST_IDLE;
        end
      end
      default: state_next = clxm_pkg::ST_IDLE;
    endcase
  end

  // Seed register and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg      <= '0;
      lcg_word      <= '0;
      xorshift_word <= '0;
      mwc_word      <= '0;
      fix_cnt       <= '0;
    end else begin
      if (seed_value_we) begin
        seed_reg <= seed_value;
      end
      case (state)
        clxm_pkg::ST_SEED: begin
          xorshift_word <= clxm_pkg::XS_SEED;
          mwc_word      <= 64'd1;
          lcg_word      <= seed_reg ^ clxm_pkg::XS_SEED;
          fix_cnt       <= 2'd3;
        end
        clxm_pkg::ST_P3: begin
          lcg_word      <= acc + clxm_pkg::LCG_ADD;
          xorshift_word <= clxm_pkg::xs_step(xorshift_word);
          mwc_word      <= prod + {32'd0, mwc_word[63:32]};
        end
        clxm_pkg::ST_FIX: begin
          // after first discarded step reload xorshift, after second reload MWC
          if (fix_cnt == 2'd3) begin
            xorshift_word <= lcg_word;
          end else if (fix_cnt == 2'd2) begin
            mwc_word <= xorshift_word;
          end
          fix_cnt <= fix_cnt - 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // LCG product accumulator: low product plus two cross terms into the upper half
  always_ff @(posedge clk) begin
    case (state)
      clxm_pkg::ST_P0: acc <= prod;
      clxm_pkg::ST_P1: acc[63:32] <= acc[63:32] + prod[31:0];
      clxm_pkg::ST_P2: acc[63:32] <= acc[63:32] + prod[31:0];
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == clxm_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == clxm_pkg::ST_OUT && out_free) begin
      m_tdata <= (clxm_pkg::lcg_temper(lcg_word) + xorshift_word) ^ mwc_word;
    end
  end

endmodule

// ===== rtl/clxm_port_checker.sv =====
// Port-level checks for the combined generator core, bound to its top level.
// Depends only on the core's ports.
module clxm_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // An accepted item keeps the input closed while the multiplier passes run
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input reopened during multiplier passes");

  // No result appears right after an item is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid ##1 !m_tvalid)
    else $error("result showed too early");

  // A new result is presented as the sequencer returns to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result presented while still busy");

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind combined_lcg_xorshift_mwc_rng_core clxm_port_checker u_clxm_port_checker (.*);

// ===== test/testbench.sv =====
// Self-checking bench for the combined LCG / xorshift / MWC random word generator.
// Uses clxm_pkg for the generator constants; needs nothing but the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 100;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        seed_value_we = 1'b0;
  logic [63:0] seed_value    = '0;
  logic        s_tvalid      = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata       = '0;   // [0] restart, [7:1] zero fill
  logic        m_tvalid;
  logic        m_tready      = 1'b0;
  logic [63:0] m_tdata;              // [63:0] deviate

  combined_lcg_xorshift_mwc_rng_core dut (
    .clk           (clk),
    .rst           (rst),
    .seed_value_we (seed_value_we),
    .seed_value    (seed_value),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generator copy: seed register and the three state words.
  logic [63:0] seed_reg = '0;
  logic [63:0] gen_lcg  = '0;
  logic [63:0] gen_xs   = '0;
  logic [63:0] gen_mwc  = '0;

  logic [63:0] expected_deviates[$];
  int          deviate_errors = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          quiet_cycles   = 0;

  function automatic logic [63:0] advance_generator();
    logic [63:0] t;
    gen_lcg = gen_lcg * clxm_pkg::LCG_MUL + clxm_pkg::LCG_ADD;
    gen_xs  = gen_xs ^ (gen_xs >> 17);
    gen_xs  = gen_xs ^ (gen_xs << 31);
    gen_xs  = gen_xs ^ (gen_xs >> 8);
    gen_mwc = {32'd0, clxm_pkg::MWC_MUL} * {32'd0, gen_mwc[31:0]} + {32'd0, gen_mwc[63:32]};
    t = gen_lcg ^ (gen_lcg << 21);
    t = t ^ (t >> 35);
    t = t ^ (t << 4);
    return (t + gen_xs) ^ gen_mwc;
  endfunction

  // On restart, re-seed and run three discarded steps; then return the next deviate.
  function automatic logic [63:0] next_deviate(input logic restart);
    logic [63:0] unused;
    if (restart) begin
      gen_xs  = clxm_pkg::XS_SEED;
      gen_mwc = 64'd1;
      gen_lcg = seed_reg ^ gen_xs;
      unused  = advance_generator();
      gen_xs  = gen_lcg;
      unused  = advance_generator();
      gen_mwc = gen_xs;
      unused  = advance_generator();
    end
    return advance_generator();
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    deviate_errors++;
    if (deviate_errors <= MAX_REPORTS)
      $display("%0t: %s: expected deviate %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // Receiver: random stall on the result side.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_deviates.size() == 0)
        note_mismatch("unexpected result", 64'd0, m_tdata);
      else if (m_tdata !== expected_deviates[0]) begin
        note_mismatch("deviate mismatch", expected_deviates[0], m_tdata);
        void'(expected_deviates.pop_front());
      end else
        void'(expected_deviates.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    expected_deviates.push_back(next_deviate(restart));
  endtask

  // Drop valid, then wait for every result and for the sequencer to go idle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_deviates.size() != 0) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    drain();
    @(negedge clk);
    seed_value_we <= 1'b1;
    seed_value    <= value;
    @(negedge clk);
    seed_value_we <= 1'b0;
    seed_reg = value;
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Before any restart only the LCG word moves; then restart on the reset seed.
  task automatic test_reset_state();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_seed_extremes();
    write_seed('1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    write_seed('0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    write_seed(64'd1);
    send_item(1'b1);
    send_item(1'b0);
    write_seed(64'h8000_0000_0000_0000);
    send_item(1'b1);
    send_item(1'b0);
    // seed equal to the xorshift start value gives an LCG word of zero
    write_seed(clxm_pkg::XS_SEED);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_v, input int n);
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    write_seed(pick_seed());
    for (int i = 0; i < n; i++) begin
      if (i == n / 2)
        write_seed(pick_seed());
      send_item($urandom_range(9) == 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_seed_extremes();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(65, 0, PHASE_ITEMS);
    test_random_traffic(0, 65, PHASE_ITEMS);
    test_random_traffic(36, 36, PHASE_ITEMS);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (deviate_errors == 0 && expected_deviates.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clxm_pkg.sv
rtl/combined_lcg_xorshift_mwc_rng_core.sv
rtl/clxm_port_checker.sv
test/testbench.sv
